// ----- rtl/core/lcwm_pkg.sv -----
// ----------------------------------------------------------------------------
// lcwm_pkg
// Shared types and constants for the low-complexity window mask: character
// classes, the result item and the base classifier.
// ----------------------------------------------------------------------------
package lcwm_pkg;

  // Width of the threshold register
  localparam int PEAK_W = 7;

  // Character codes treated as bases
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  // Index of each base in the count array
  localparam logic [1:0] IDX_A = 2'd0;
  localparam logic [1:0] IDX_C = 2'd1;
  localparam logic [1:0] IDX_G = 2'd2;
  localparam logic [1:0] IDX_T = 2'd3;

  // Class of one character
  typedef struct packed {
    logic       is_base;
    logic [1:0] idx;
  } cls_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_char;
    logic       masked;
    logic       last_result;
  } res_t;

  function automatic cls_t base_class(input logic [7:0] c);
    cls_t r;
    r.is_base = 1'b1;
    r.idx     = IDX_A;
    unique case (c)
      CHAR_A:  r.idx = IDX_A;
      CHAR_C:  r.idx = IDX_C;
      CHAR_G:  r.idx = IDX_G;
      CHAR_T:  r.idx = IDX_T;
      default: r.is_base = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/lcwm_store.sv -----
// ----------------------------------------------------------------------------
// lcwm_store
// Circular character store for the window: one write port, one registered
// read port, with the write forwarded when both hit the same entry.
// ----------------------------------------------------------------------------
module lcwm_store #(
  parameter int WINDOW = 16,
  parameter int AW     = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [WINDOW];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, new data wins on a same-entry collision
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/lcwm_out_queue.sv -----
// ----------------------------------------------------------------------------
// lcwm_out_queue
// Two-entry output buffer: holds finished items so the input side keeps
// moving while the downstream side stalls, until both entries are taken.
// ----------------------------------------------------------------------------
module lcwm_out_queue
  import lcwm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_item,
  output logic full,
  output logic m_tvalid,
  input  logic m_tready,
  output res_t head_item
);

  res_t       q0;
  res_t       q1;
  logic [1:0] count;
  logic       pop;

  assign pop       = (count != 2'd0) && m_tready;
  assign full      = (count == 2'd2);
  assign m_tvalid  = (count != 2'd0);
  assign head_item = q0;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Payload shift
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (count == 2'd1)) begin
        q0 <= push_item;
      end else begin
        q0 <= q1;
      end
      if (push && (count == 2'd2)) begin
        q1 <= push_item;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        q0 <= push_item;
      end else begin
        q1 <= push_item;
      end
    end
  end

endmodule

// ----- rtl/core/low_complexity_window_mask.sv -----
// ----------------------------------------------------------------------------
// low_complexity_window_mask
// Sliding-window low-complexity masker for a stream of DNA characters.
// ----------------------------------------------------------------------------
// Characters enter on s_* one per cycle while s_tready is high and are held
// in a circular store of WINDOW entries, with running counts of A, C, G, T
// and of other codes kept in registers. Each full, all-base window whose
// largest base count reaches min_peak_count marks every held position as
// masked. Once the window is full, each accepted item without tlast releases
// the oldest character on m_*. An item with tlast set is taken in and then
// the held characters, up to WINDOW, drain one per cycle while the output
// queue has room, with s_tready low; tlast marks the final one. The user must
// write the threshold on cfg_* while no item is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module low_complexity_window_mask
  import lcwm_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic              clk,
  input  logic              rst,
  // Input items
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] base_char
  input  logic              s_tlast,   // last_item
  // Result items
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_char
  output logic              m_tuser,   // [0] masked
  output logic              m_tlast,   // last_result
  // Threshold write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PEAK_W-1:0] cfg_data   // min_peak_count
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW = $clog2(WINDOW + 1);
  localparam int CW = FW;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } state_t;

  state_t            state;
  logic [AW-1:0]     head;
  logic [FW-1:0]     fill;
  logic [FW-1:0]     mask_rem;
  logic [CW-1:0]     base_cnt [4];
  logic [CW-1:0]     nonbase_cnt;
  logic [PEAK_W-1:0] min_peak;

  logic              accept;
  logic              q_full;
  cls_t              new_cls;
  cls_t              old_cls;
  logic [7:0]        rd_char;
  logic [AW:0]       tail_sum;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     rd_addr;
  logic [FW-1:0]     fill_ins;
  logic              full_ins;
  logic [CW-1:0]     cnt_ins [4];
  logic [CW-1:0]     cnt_pop [4];
  logic [CW-1:0]     nonbase_ins;
  logic [CW-1:0]     nonbase_pop;
  logic              peak_hit;
  logic              qualify;
  logic [FW-1:0]     mask_ins;
  logic              pop_run;
  logic              pop_flush;
  logic              pop;
  logic [FW-1:0]     pop_mask;
  res_t              res;
  res_t              out_item;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_RUN) && !q_full;
  assign accept    = s_tvalid && s_tready;

  assign new_cls = base_class(s_tdata);
  assign old_cls = base_class(rd_char);

  // Store addressing
  assign tail_sum = (AW+1)'(head) + (AW+1)'(fill);
  assign tail     = (tail_sum >= (AW+1)'(WINDOW)) ? AW'(tail_sum - (AW+1)'(WINDOW))
                                                  : AW'(tail_sum);
  assign head_inc = (head == AW'(WINDOW - 1)) ? '0 : head + 1'b1;
  assign rd_addr  = pop ? head_inc : head;

  // Counts after taking in the new character, and after dropping the oldest
  always_comb begin
    peak_hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      cnt_ins[k] = base_cnt[k] + CW'(new_cls.is_base && (new_cls.idx == 2'(k)));
      cnt_pop[k] = cnt_ins[k] - CW'(old_cls.is_base && (old_cls.idx == 2'(k)));
      if (PEAK_W'(cnt_ins[k]) >= min_peak) begin
        peak_hit = 1'b1;
      end
    end
    nonbase_ins = nonbase_cnt + CW'(!new_cls.is_base);
    nonbase_pop = nonbase_ins - CW'(!old_cls.is_base);
  end

  // Window evaluation
  assign fill_ins = fill + 1'b1;
  assign full_ins = (fill_ins == FW'(WINDOW));
  assign qualify  = full_ins && (nonbase_ins == '0) && peak_hit;
  assign mask_ins = qualify ? FW'(WINDOW) : mask_rem;

  // Release of the oldest character
  assign pop_run   = accept && !s_tlast && full_ins;
  assign pop_flush = (state == ST_FLUSH) && !q_full;
  assign pop       = pop_run || pop_flush;
  assign pop_mask  = pop_run ? mask_ins : mask_rem;

  assign res.out_char    = rd_char;
  assign res.masked      = (pop_mask != '0);
  assign res.last_result = pop_flush && (fill == FW'(1));

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_peak <= PEAK_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      min_peak <= cfg_data;
    end
  end

  // Window control and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      head        <= '0;
      fill        <= '0;
      mask_rem    <= '0;
      nonbase_cnt <= '0;
      for (int k = 0; k < 4; k++) begin
        base_cnt[k] <= '0;
      end
    end else begin
      unique case (state)
        ST_RUN: begin
          if (accept) begin
            if (s_tlast) begin
              // take the character in, then drain
              fill        <= fill_ins;
              mask_rem    <= mask_ins;
              nonbase_cnt <= '0;
              for (int k = 0; k < 4; k++) begin
                base_cnt[k] <= '0;
              end
              state <= ST_FLUSH;
            end else if (full_ins) begin
              // steady state: one in, one out
              mask_rem    <= (mask_ins != '0) ? mask_ins - 1'b1 : mask_ins;
              head        <= head_inc;
              nonbase_cnt <= nonbase_pop;
              for (int k = 0; k < 4; k++) begin
                base_cnt[k] <= cnt_pop[k];
              end
            end else begin
              fill        <= fill_ins;
              nonbase_cnt <= nonbase_ins;
              for (int k = 0; k < 4; k++) begin
                base_cnt[k] <= cnt_ins[k];
              end
            end
          end
        end
        ST_FLUSH: begin
          if (pop_flush) begin
            head <= head_inc;
            fill <= fill - 1'b1;
            if (fill == FW'(1)) begin
              mask_rem <= '0;
              state    <= ST_RUN;
            end else if (mask_rem != '0) begin
              mask_rem <= mask_rem - 1'b1;
            end
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  lcwm_store #(
    .WINDOW (WINDOW),
    .AW     (AW)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (tail),
    .wdata (s_tdata),
    .raddr (rd_addr),
    .rdata (rd_char)
  );

  lcwm_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pop),
    .push_item (res),
    .full      (q_full),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .head_item (out_item)
  );

  assign m_tdata = out_item.out_char;
  assign m_tuser = out_item.masked;
  assign m_tlast = out_item.last_result;

endmodule
